FILE: sv/ftws_pkg.sv
// Shared constants, command and status types for the frame time window statistics block.
// No dependencies; every other file imports this package.
package ftws_pkg;

  localparam int DATA_W    = 24;  // frame time fields
  localparam int ALPHA_W   = 16;  // Q0.16 smoothing weight
  localparam int FRAC_W    = 16;  // fraction bits of the average
  localparam int FX_W      = 40;  // Q24.16 average
  localparam int RATE_W    = 28;  // Q8 frames per second
  localparam int CNT_OUT_W = 8;   // window_count port
  localparam int DEPTH_DEF = 128;

  // shared divider: 44-bit dividend covers the rate numerator and any window sum
  localparam int DIV_W = 44;
  localparam int QUO_W = 28;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;
  localparam logic [DATA_W-1:0]  MIN_CAP     = 24'd9999000;
  localparam logic [RATE_W-1:0]  RATE_MAX    = 28'd256000000;
  // 256e6 * 2^16
  localparam logic [DIV_W-1:0]   RATE_NUM    = 44'd16777216000000;

  typedef struct packed {
    logic accept;       // take the input item, write history, capture difference
    logic ema_lo;       // multiply alpha by low part of difference
    logic ema_hi;       // multiply alpha by high part of difference
    logic ema_sum;      // combine partial products
    logic ema_upd;      // update the average
    logic div_start;    // launch shared divider
    logic div_sel_mean; // divider operands: window sum / count
    logic cap_rate;     // capture rate quotient
    logic scan_rd;      // read next history entry
    logic load_out;     // load the result register
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

FILE: sv/ftws_div.sv
// Iterative restoring divider, one quotient bit per cycle, shared by rate and mean.
// Depends on ftws_pkg.
module ftws_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ftws_pkg::DIV_W-1:0] dividend,
  input  logic [ftws_pkg::FX_W-1:0]  divisor,
  output logic                      done,
  output logic [ftws_pkg::QUO_W-1:0] quotient
);
  import ftws_pkg::*;

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  num;
  logic [FX_W-1:0]   rem;
  logic [FX_W-1:0]   dvs;
  logic [STEP_W-1:0] steps;
  logic [FX_W:0]     rem_sh;
  logic [FX_W:0]     rem_diff;
  logic              fits;

  assign rem_sh   = {rem, num[DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign fits     = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= STEP_W'(DIV_W);
      end else if (steps != '0) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (steps != '0) begin
      num      <= num << 1;
      rem      <= fits ? rem_diff[FX_W-1:0] : rem_sh[FX_W-1:0];
      // leading quotient bits are zero for every operand pair in use
      quotient <= {quotient[QUO_W-2:0], fits};
    end
  end

endmodule

FILE: sv/ftws_dp.sv
// Datapath: history memory, running average, window scan, rate and mean via the divider.
// Depends on ftws_pkg and ftws_div.
module ftws_dp #(
  parameter int DEPTH = ftws_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ftws_pkg::cmd_t                cmd,
  output ftws_pkg::status_t             status,
  input  logic [ftws_pkg::DATA_W-1:0]   frame_time_us,
  input  logic                          cfg_write_en,
  input  logic [ftws_pkg::ALPHA_W-1:0]  cfg_write_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [ftws_pkg::DATA_W-1:0]   smoothed_time_us,
  output logic [ftws_pkg::RATE_W-1:0]   rate_fps_q8,
  output logic [ftws_pkg::DATA_W-1:0]   window_mean_us,
  output logic [ftws_pkg::DATA_W-1:0]   window_min_us,
  output logic [ftws_pkg::DATA_W-1:0]   window_max_us,
  output logic [ftws_pkg::CNT_OUT_W-1:0] window_count
);
  import ftws_pkg::*;

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int SUM_W  = DATA_W + AW;
  localparam int LO_W   = 20;
  localparam int HI_W   = FX_W + 1 - LO_W;
  localparam int PROD_W = ALPHA_W + 1 + HI_W;
  localparam int TOT_W  = PROD_W + LO_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic              rd_valid;

  logic [AW-1:0]      wp;
  logic [AW-1:0]      scan_idx;
  logic               full;
  logic               wp_last;
  logic [CW-1:0]      count;
  logic [ALPHA_W-1:0] alpha;

  logic [FX_W-1:0]          fx;
  logic                     fx_was_zero;
  logic [DATA_W-1:0]        sample;
  logic signed [FX_W:0]     delta;
  logic signed [ALPHA_W:0]  mul_a;
  logic signed [HI_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] prod_lo;
  logic signed [PROD_W-1:0] prod_hi;
  logic signed [TOT_W-1:0]  ema_total;

  logic [SUM_W-1:0]  sum;
  logic [DATA_W-1:0] lo;
  logic [DATA_W-1:0] hi;
  logic [RATE_W-1:0] rate;

  logic [DIV_W-1:0] div_dividend;
  logic [FX_W-1:0]  div_divisor;
  logic [QUO_W-1:0] div_quotient;
  logic             div_done;

  assign wp_last = (wp == AW'(DEPTH - 1));

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ALPHA_RESET;
    end else if (cfg_write_en) begin
      alpha <= cfg_write_data;
    end
  end

  // ring pointer and fill state
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      full <= 1'b0;
    end else if (cmd.accept) begin
      wp   <= wp_last ? '0 : wp + 1'b1;
      full <= full | wp_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      count <= (full || wp_last) ? CW'(DEPTH) : CW'(wp) + 1'b1;
    end
  end

  // history memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[wp] <= frame_time_us;
    end
    rd_data <= mem[scan_idx];
  end

  // average: signed difference split into a 20-bit low part and a 21-bit high part on one multiplier
  assign mul_a = $signed({1'b0, alpha});
  assign mul_b = cmd.ema_hi ? $signed(delta[FX_W:LO_W]) : $signed({1'b0, delta[LO_W-1:0]});
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample      <= frame_time_us;
      fx_was_zero <= (fx == '0);
      delta       <= $signed({1'b0, frame_time_us, {FRAC_W{1'b0}}}) - $signed({1'b0, fx});
    end
    if (cmd.ema_lo) begin
      prod_lo <= mul_p;
    end
    if (cmd.ema_hi) begin
      prod_hi <= mul_p;
    end
    if (cmd.ema_sum) begin
      ema_total <= (TOT_W'(prod_hi) <<< LO_W) + TOT_W'(prod_lo);
    end
  end

  // arithmetic shift of the product floors toward minus infinity
  always_ff @(posedge clk) begin
    if (rst) begin
      fx <= '0;
    end else if (cmd.ema_upd) begin
      fx <= fx_was_zero ? {sample, {FRAC_W{1'b0}}} : fx + ema_total[FX_W+FRAC_W-1:FRAC_W];
    end
  end

  // window scan
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_idx <= '0;
      sum      <= '0;
      lo       <= MIN_CAP;
      hi       <= '0;
    end else begin
      if (cmd.scan_rd) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (rd_valid) begin
        sum <= sum + SUM_W'(rd_data);
        if (rd_data < lo) begin
          lo <= rd_data;
        end
        if (rd_data > hi) begin
          hi <= rd_data;
        end
      end
    end
  end

  // shared divider
  assign div_dividend = cmd.div_sel_mean ? DIV_W'(sum) : RATE_NUM;
  assign div_divisor  = cmd.div_sel_mean ? FX_W'(count) : fx;

  ftws_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // nonzero averages under one microsecond saturate the rate; a zero average gives a zero rate
  always_ff @(posedge clk) begin
    if (cmd.cap_rate) begin
      if (fx == '0) begin
        rate <= '0;
      end else if (fx[FX_W-1:FRAC_W] == '0) begin
        rate <= RATE_MAX;
      end else begin
        rate <= div_quotient;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      smoothed_time_us <= fx[FX_W-1:FRAC_W];
      rate_fps_q8      <= rate;
      window_mean_us   <= div_quotient[DATA_W-1:0];
      window_min_us    <= lo;
      window_max_us    <= hi;
      window_count     <= CNT_OUT_W'(count);
    end
  end

  assign status.div_done  = div_done;
  assign status.scan_last = (CW'(scan_idx) == count - 1'b1);
  assign status.out_free  = !out_valid || out_ready;

endmodule

FILE: sv/ftws_ctrl.sv
// Controller state machine sequencing average update, rate division, window scan and mean.
// Depends on ftws_pkg.
module ftws_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ftws_pkg::status_t status,
  output ftws_pkg::cmd_t    cmd
);
  import ftws_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_EMA_LO    = 12'b0000_0000_0010,
    S_EMA_HI    = 12'b0000_0000_0100,
    S_EMA_SUM   = 12'b0000_0000_1000,
    S_EMA_UPD   = 12'b0000_0001_0000,
    S_RATE_GO   = 12'b0000_0010_0000,
    S_RATE_WAIT = 12'b0000_0100_0000,
    S_SCAN      = 12'b0000_1000_0000,
    S_DRAIN     = 12'b0001_0000_0000,
    S_MEAN_GO   = 12'b0010_0000_0000,
    S_MEAN_WAIT = 12'b0100_0000_0000,
    S_FINISH    = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EMA_LO;
        end
      end
      S_EMA_LO: begin
        cmd.ema_lo = 1'b1;
        state_next = S_EMA_HI;
      end
      S_EMA_HI: begin
        cmd.ema_hi = 1'b1;
        state_next = S_EMA_SUM;
      end
      S_EMA_SUM: begin
        cmd.ema_sum = 1'b1;
        state_next  = S_EMA_UPD;
      end
      S_EMA_UPD: begin
        cmd.ema_upd = 1'b1;
        state_next  = S_RATE_GO;
      end
      S_RATE_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_RATE_WAIT;
      end
      S_RATE_WAIT: begin
        if (status.div_done) begin
          cmd.cap_rate = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_MEAN_GO;
      end
      S_MEAN_GO: begin
        cmd.div_start    = 1'b1;
        cmd.div_sel_mean = 1'b1;
        state_next       = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (status.div_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/frame_time_window_statistics.sv
// Frame time window statistics: top level joining controller and datapath.
// Items are taken one at a time: in_ready is high only while idle, so the next item
// waits until the previous one has been through both divider passes and the history
// scan, which reads one entry per cycle.
// Reset: synchronous, clears pointer, fill flag, average, alpha (to 6554) and result valid.
// History memory is not cleared; only written entries are ever read.
module frame_time_window_statistics #(
  parameter int DEPTH = ftws_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // config: alpha, Q0.16
  input  logic                           cfg_write_en,
  input  logic [ftws_pkg::ALPHA_W-1:0]   cfg_write_data,
  // input items
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ftws_pkg::DATA_W-1:0]    frame_time_us,
  // result items
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ftws_pkg::DATA_W-1:0]    smoothed_time_us,
  output logic [ftws_pkg::RATE_W-1:0]    rate_fps_q8,
  output logic [ftws_pkg::DATA_W-1:0]    window_mean_us,
  output logic [ftws_pkg::DATA_W-1:0]    window_min_us,
  output logic [ftws_pkg::DATA_W-1:0]    window_max_us,
  output logic [ftws_pkg::CNT_OUT_W-1:0] window_count
);
  import ftws_pkg::*;

  cmd_t    ctrl_cmd;
  status_t dp_status;

  // The controller walks each item through: average update (four steps on one
  // 17x21 multiplier), rate division, history scan, mean division, result load.
  // The result sits in an output register, so a new item is taken while the
  // previous result still waits for out_ready.
  ftws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd      (ctrl_cmd)
  );

  // History ring, average, min/max/sum scan and the shared divider.
  ftws_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (ctrl_cmd),
    .status           (dp_status),
    .frame_time_us    (frame_time_us),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .smoothed_time_us (smoothed_time_us),
    .rate_fps_q8      (rate_fps_q8),
    .window_mean_us   (window_mean_us),
    .window_min_us    (window_min_us),
    .window_max_us    (window_max_us),
    .window_count     (window_count)
  );

endmodule

FILE: sv/ftws_checker.sv
// Port-level checks for frame_time_window_statistics, attached by bind.
// Depends on ftws_pkg.
module ftws_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [ftws_pkg::DATA_W-1:0]    smoothed_time_us,
  input logic [ftws_pkg::RATE_W-1:0]    rate_fps_q8,
  input logic [ftws_pkg::DATA_W-1:0]    window_mean_us,
  input logic [ftws_pkg::DATA_W-1:0]    window_min_us,
  input logic [ftws_pkg::DATA_W-1:0]    window_max_us,
  input logic [ftws_pkg::CNT_OUT_W-1:0] window_count
);
  import ftws_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(smoothed_time_us)
      && $stable(window_mean_us) && $stable(window_count))
    else $error("result changed while stalled");

  // mean lies between min and max
  a_window_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (window_min_us <= window_mean_us) && (window_mean_us <= window_max_us))
    else $error("window min/mean/max out of order");

  a_min_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_min_us <= MIN_CAP)
    else $error("window min above cap");

  // rate stays within RATE_MAX and is zero only when the average is zero
  a_rate: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rate_fps_q8 <= RATE_MAX) && ((rate_fps_q8 != '0) || (smoothed_time_us == '0)))
    else $error("rate inconsistent with average");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind frame_time_window_statistics ftws_checker u_ftws_checker (.*);
